[hw/rtl/sqbp_pkg.sv]
// shared types and constants for the scalar quantizer and bit packer
package sqbp_pkg;

   localparam int CODE_BITS      = 3;
   localparam int MAX_BOUNDS     = 7;
   localparam int DEF_NUM_BOUNDS = 7;
   localparam int MAX_RESULTS    = 3;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;

   // register indexes on the configuration port
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_BOUND_0 = 3'd1;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef logic [MAX_BOUNDS-1:0][7:0] bounds_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       last_of_stream;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] res;
      logic [1:0]                num;
      logic [7:0]                store;
      logic [2:0]                count;
   } step_type;

endpackage

[hw/rtl/sqbp_step.sv]
// per-item datapath: quantize and pack, or unpack and reconstruct
module sqbp_step #(
   parameter int NUM_BOUNDS = sqbp_pkg::DEF_NUM_BOUNDS
) (
   input  logic                mode,
   input  sqbp_pkg::bounds_type bounds,
   input  logic [7:0]          store,
   input  logic [2:0]          count,
   input  sqbp_pkg::req_type   req,
   output sqbp_pkg::step_type  step
);
   import sqbp_pkg::*;

   localparam logic [CODE_BITS-1:0] NB = CODE_BITS'(NUM_BOUNDS);

   function automatic logic [7:0] low_mask(input logic [2:0] n);
      return ~(8'hFF << n);
   endfunction

   function automatic logic [CODE_BITS-1:0] quantize(input logic [7:0] pix,
                                                     input bounds_type b);
      logic [CODE_BITS-1:0] q;
      q = NB;
      for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
         if (pix < b[i]) begin
            q = CODE_BITS'(i);
         end
      end
      return q;
   endfunction

   function automatic logic [7:0] midpoint(input logic [CODE_BITS-1:0] idx_raw,
                                           input bounds_type b);
      logic [CODE_BITS-1:0] idx;
      logic signed [9:0]    lo;
      logic signed [9:0]    hi;
      logic signed [9:0]    d;
      logic signed [9:0]    v;
      idx = (idx_raw > NB) ? NB : idx_raw;
      lo  = (idx == '0) ? 10'sd0 : $signed({2'b00, b[idx - 1'b1]});
      hi  = (idx == NB) ? 10'sd256 : $signed({2'b00, b[idx]});
      d   = hi - lo;
      // halve rounding toward zero
      v   = ((d + $signed({9'd0, d[9]})) >>> 1) + lo;
      return v[7:0];
   endfunction

   always_comb begin
      logic [15:0] acc;
      logic [15:0] rem;
      logic [4:0]  n;
      logic [4:0]  nrem;
      logic [1:0]  k;
      step = '0;
      acc  = {8'd0, store & low_mask(count)};
      n    = {2'b00, count};
      rem  = acc;
      nrem = n;
      k    = 2'd0;
      if (mode == MODE_ENCODE) begin
         acc  = acc | ({13'd0, quantize(req.in_byte, bounds)} << count);
         n    = n + 5'd3;
         rem  = acc;
         nrem = n;
         if (n >= 5'd8) begin
            step.res[0].out_byte = acc[7:0];
            rem  = acc >> 8;
            nrem = n - 5'd8;
            k    = 2'd1;
         end
         // flush the zero-padded partial byte at end of stream
         if (req.stream_end && nrem != 5'd0) begin
            step.res[k].out_byte = rem[7:0];
            k = k + 2'd1;
         end
      end else begin
         acc = acc | ({8'd0, req.in_byte} << count);
         n   = n + 5'd8;
         step.res[0].out_byte = midpoint(acc[2:0], bounds);
         step.res[1].out_byte = midpoint(acc[5:3], bounds);
         step.res[2].out_byte = midpoint(acc[8:6], bounds);
         if (n >= 5'd9) begin
            k = 2'd3;
            rem  = acc >> 9;
            nrem = n - 5'd9;
         end else if (n >= 5'd6) begin
            k = 2'd2;
            rem  = acc >> 6;
            nrem = n - 5'd6;
         end else if (n >= 5'd3) begin
            k = 2'd1;
            rem  = acc >> 3;
            nrem = n - 5'd3;
         end
      end
      if (k != 2'd0) begin
         step.res[k - 2'd1].last_of_item   = 1'b1;
         step.res[k - 2'd1].last_of_stream = req.stream_end;
      end
      step.num = k;
      if (req.stream_end) begin
         step.store = 8'd0;
         step.count = 3'd0;
      end else begin
         step.store = rem[7:0] & low_mask(nrem[2:0]);
         step.count = nrem[2:0];
      end
   end

endmodule

[hw/rtl/scalar_quantizer_bit_packer_core.sv]
// top level: configuration registers, bit state and result buffer
// Each accepted byte is processed in the cycle it is accepted and its results are loaded
// into a three-entry result buffer that drains one result per cycle on the rsp port while
// rsp_ready is high. In encode mode an item gives zero or one packed byte, or two when a
// completed byte and the end-of-stream flush byte both go out. In decode mode an item gives
// two or three reconstructed pixels, handed out one at a time through the single result
// port. A new byte is accepted in the cycle the buffer hands out its last pending result.
// Writing the mode register restarts the stream and drops any pending bits.
module scalar_quantizer_bit_packer_core #(
   parameter int NUM_BOUNDS = sqbp_pkg::DEF_NUM_BOUNDS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sqbp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sqbp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sqbp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sqbp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sqbp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import sqbp_pkg::*;

   logic       mode_ff, mode_in;
   bounds_type bounds_ff, bounds_in;
   logic [7:0] store_ff, store_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] num_ff, num_in;
   rsp_type [MAX_RESULTS-1:0] res_ff, res_in;

   step_type   step;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       csr_wr;
   logic [2:0] csr_idx;

   sqbp_step #(
      .NUM_BOUNDS(NUM_BOUNDS)
   ) u_step (
      .mode  (mode_ff),
      .bounds(bounds_ff),
      .store (store_ff),
      .count (count_ff),
      .req   (req_data),
      .step  (step)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == REG_MODE) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
      end else begin
         csr_prdata = {{(CSR_DATA_W-8){1'b0}}, bounds_ff[csr_idx - REG_BOUND_0]};
      end
   end

   assign rsp_valid = (num_ff != 2'd0);
   assign rsp_data  = res_ff[0];
   assign rsp_xfer  = rsp_valid & rsp_ready;
   // buffer is free once its last pending result goes out
   assign req_ready = (num_ff == 2'd0) || (num_ff == 2'd1 && rsp_ready);
   assign req_xfer  = req_valid & req_ready;

   always_comb begin
      mode_in   = mode_ff;
      bounds_in = bounds_ff;
      store_in  = store_ff;
      count_in  = count_ff;
      num_in    = num_ff;
      res_in    = res_ff;
      if (req_xfer) begin
         store_in = step.store;
         count_in = step.count;
         num_in   = step.num;
         res_in   = step.res;
      end else if (rsp_xfer) begin
         num_in    = num_ff - 2'd1;
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
      end
      if (csr_wr) begin
         if (csr_idx == REG_MODE) begin
            mode_in  = csr_pwdata[0];
            store_in = 8'd0;
            count_in = 3'd0;
         end else begin
            bounds_in[csr_idx - REG_BOUND_0] = csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         for (int i = 0; i < MAX_BOUNDS; i++) begin
            bounds_ff[i] <= 8'(32 * (i + 1));
         end
         store_ff <= 8'd0;
         count_ff <= 3'd0;
         num_ff   <= 2'd0;
      end else begin
         mode_ff   <= mode_in;
         bounds_ff <= bounds_in;
         store_ff  <= store_in;
         count_ff  <= count_in;
         num_ff    <= num_in;
      end
   end

endmodule

[sim/tb_scalar_quantizer_bit_packer_core.sv]
// testbench for the scalar quantizer and bit packer core: scoreboard class, drivers and checks
`timescale 1ns / 1ps

module tb_scalar_quantizer_bit_packer_core;
   import sqbp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int NB          = DEF_NUM_BOUNDS;

   // bit state, configuration and the queue of outputs still owed by the core
   class codec_tracker;
      logic       mode_q;
      bounds_type bound_q;
      logic [7:0] store_q;
      logic [2:0] count_q;
      rsp_type    due[$];
      int         errors;

      function new();
         mode_q  = MODE_ENCODE;
         for (int i = 0; i < MAX_BOUNDS; i++) bound_q[i] = 8'(32 * (i + 1));
         store_q = '0;
         count_q = '0;
         errors  = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         if (idx == REG_MODE) begin
            mode_q  = value[0];
            store_q = '0;
            count_q = '0;
         end else begin
            bound_q[idx - REG_BOUND_0] = value[7:0];
         end
      endfunction

      function int level_of(logic [7:0] pix);
         for (int i = 0; i < NB; i++) begin
            if (pix < bound_q[i]) return i;
         end
         return NB;
      endfunction

      // interval midpoint; unordered boundaries give a signed span
      function logic [7:0] center_of(int idx);
         int lo, hi, v;
         if (idx > NB) idx = NB;
         lo = (idx == 0) ? 0 : int'(bound_q[idx - 1]);
         hi = (idx == NB) ? 256 : int'(bound_q[idx]);
         v  = (hi - lo) / 2 + lo;
         return 8'(v);
      endfunction

      function void absorb_byte(req_type r);
         int      acc, n, k;
         rsp_type row [MAX_RESULTS];
         n   = int'(count_q);
         acc = int'(store_q) & ((1 << n) - 1);
         k   = 0;
         if (mode_q == MODE_ENCODE) begin
            acc |= level_of(r.in_byte) << n;
            n += CODE_BITS;
            if (n >= 8) begin
               row[k] = '{out_byte: 8'(acc), last_of_item: 1'b0, last_of_stream: 1'b0};
               k++;
               acc >>= 8;
               n -= 8;
            end
            // flush the zero-padded partial byte at end of stream
            if (r.stream_end && n > 0) begin
               row[k] = '{out_byte: 8'(acc), last_of_item: 1'b0, last_of_stream: 1'b0};
               k++;
               acc = 0;
               n = 0;
            end
         end else begin
            acc |= int'(r.in_byte) << n;
            n += 8;
            while (n >= CODE_BITS && k < MAX_RESULTS) begin
               row[k] = '{out_byte: center_of(acc & ((1 << CODE_BITS) - 1)),
                          last_of_item: 1'b0, last_of_stream: 1'b0};
               k++;
               acc >>= CODE_BITS;
               n -= CODE_BITS;
            end
         end
         if (r.stream_end) begin
            acc = 0;
            n = 0;
         end
         store_q = 8'(acc & ((1 << n) - 1));
         count_q = 3'(n);
         if (k > 0) begin
            row[k - 1].last_of_item   = 1'b1;
            row[k - 1].last_of_stream = r.stream_end;
         end
         for (int i = 0; i < k; i++) due.push_back(row[i]);
      endfunction

      function void match_output(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer, expected none, actual %h/%b/%b", $time,
                     got.out_byte, got.last_of_item, got.last_of_stream);
            return;
         end
         want = due.pop_front();
         if (got.out_byte !== want.out_byte || got.last_of_item !== want.last_of_item ||
             got.last_of_stream !== want.last_of_stream) begin
            errors++;
            $display("%0t: mismatch, expected %h/%b/%b, actual %h/%b/%b", $time,
                     want.out_byte, want.last_of_item, want.last_of_stream,
                     got.out_byte, got.last_of_item, got.last_of_stream);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   codec_tracker trk;
   int           hold_left = 0;
   logic         steady = 1'b0;
   int           cycle_count = 0;

   scalar_quantizer_bit_packer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_scalar_quantizer_bit_packer_core: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) trk.match_output(rsp_data);
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      else if (r < 94) return $urandom_range(3, 8);
      else return $urandom_range(15, 40);
   endfunction

   // result side: long hold from the main flow first, then random stalls
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   task automatic offer(input logic [7:0] b, input logic last);
      int g;
      g = steady ? 0 : gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = '{in_byte: b, stream_end: last};
      do @(posedge clock); while (!req_ready);
      trk.absorb_byte(req_data);
   endtask

   // wait for every owed output, then let the last zero-output byte finish
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (trk.due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // unused high bits of pwdata carry junk
   task automatic write_csr(input logic [2:0] idx, input logic [7:0] field);
      logic [31:0] value;
      if (idx == REG_MODE) value = ($urandom() & 32'hFFFF_FFFE) | {31'd0, field[0]};
      else value = ($urandom() & 32'hFFFF_FF00) | {24'd0, field};
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      trk.write_reg(idx, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic load_bounds(input bounds_type b);
      for (int i = 0; i < MAX_BOUNDS; i++) write_csr(3'(int'(REG_BOUND_0) + i), b[i]);
   endtask

   task automatic random_setup(input int ph);
      bounds_type b;
      int         cur;
      case (ph % 4)
         0: begin
            cur = $urandom_range(0, 60);
            for (int i = 0; i < MAX_BOUNDS; i++) begin
               b[i] = 8'(cur);
               cur = cur + int'($urandom_range(0, 40));
               if (cur > 255) cur = 255;
            end
         end
         1: for (int i = 0; i < MAX_BOUNDS; i++) b[i] = 8'($urandom);
         2: for (int i = 0; i < MAX_BOUNDS; i++) b[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: begin
            cur = 255 - int'($urandom_range(0, 30));
            for (int i = 0; i < MAX_BOUNDS; i++) begin
               b[i] = 8'(cur);
               cur = cur - int'($urandom_range(0, 40));
               if (cur < 0) cur = 0;
            end
         end
      endcase
      // skipping the mode write now and then keeps pending bits across the new boundaries
      if (ph % 3 != 2) write_csr(REG_MODE, $urandom_range(0, 1) ? 8'(MODE_DECODE) : 8'(MODE_ENCODE));
      load_bounds(b);
   endtask

   task automatic random_run(input int count);
      int         left, len;
      logic [7:0] b;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 12);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            if (trk.mode_q == MODE_ENCODE && $urandom_range(0, 2) == 0)
               b = trk.bound_q[$urandom_range(0, NB - 1)] + 8'($urandom_range(0, 2)) - 8'd1;
            else
               b = 8'($urandom);
            offer(b, (i == len - 1) && ($urandom_range(0, 9) != 0));
         end
         left -= len;
      end
   endtask

   initial begin
      trk = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // encode with reset boundaries: eight codes fill three bytes exactly
      offer(8'd0, 1'b0);
      offer(8'd255, 1'b0);
      offer(8'd31, 1'b0);
      offer(8'd32, 1'b0);
      offer(8'd223, 1'b0);
      offer(8'd224, 1'b0);
      offer(8'd128, 1'b0);
      offer(8'd127, 1'b1);
      // partial byte flush at end of stream
      offer(8'd96, 1'b0);
      offer(8'd200, 1'b1);

      settle();
      write_csr(REG_MODE, 8'(MODE_DECODE));
      offer(8'h00, 1'b0);
      offer(8'hFF, 1'b0);
      offer(8'hA5, 1'b0);
      offer(8'h5A, 1'b0);
      // boundary write mid-stream keeps the two pending bits
      settle();
      write_csr(3'(int'(REG_BOUND_0) + 6), 8'd255);
      offer(8'h3C, 1'b1);

      // descending boundaries give negative spans
      settle();
      load_bounds({8'd0, 8'd20, 8'd60, 8'd100, 8'd150, 8'd200, 8'd250});
      offer(8'hFF, 1'b0);
      offer(8'h88, 1'b0);
      offer(8'h11, 1'b1);

      settle();
      write_csr(REG_MODE, 8'(MODE_ENCODE));
      load_bounds('0);
      offer(8'd0, 1'b0);
      offer(8'd255, 1'b1);
      settle();
      load_bounds('1);
      offer(8'd255, 1'b0);
      offer(8'd254, 1'b0);
      offer(8'd0, 1'b1);

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         random_setup(ph);
         @(posedge clock);
         steady = (ph == 2);
         hold_left = (ph == 5) ? 60 : 0;
         random_run(22);
      end

      @(posedge clock);
      steady = 1'b0;
      @(negedge clock);
      req_valid = 1'b0;
      while (trk.due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (trk.errors == 0) begin
         $display("tb_scalar_quantizer_bit_packer_core: clean");
      end else begin
         $display("tb_scalar_quantizer_bit_packer_core: errors");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/sqbp_pkg.sv
hw/rtl/sqbp_step.sv
hw/rtl/scalar_quantizer_bit_packer_core.sv
sim/tb_scalar_quantizer_bit_packer_core.sv
